### sv/agk_pkg.sv
// ----------------------------------------------------------------------------
// agk_pkg
// Shared types, constants and the exponent fraction function for the ARD
// squared-exponential kernel element.
// ----------------------------------------------------------------------------
package agk_pkg;

	localparam int GK_DIMS       = 16;
	localparam int GK_TBL_DEPTH  = 16;
	localparam int GK_TBL_AW     = 4;
	localparam int GK_COORD_W    = 16;
	localparam int GK_SCALE_W    = 16;
	localparam int GK_AMP_W      = 16;
	localparam int GK_COV_W      = 32;
	localparam int GK_MUL_W      = 32;
	localparam int GK_ROM_W      = 17;
	localparam int GK_ROM_DEPTH  = 256;

	localparam logic [15:0] GK_AMP_RESET   = 16'd256;
	// log2(e)/2 in Q0.32
	localparam logic [31:0] GK_LOG2E_HALF  = 32'd3098164010;
	// results are zero once n reaches this
	localparam logic [15:0] GK_N_ZERO      = 16'd44;

	// 2^(-2^k/256) in Q0.32
	localparam logic [31:0] GK_EXP_STEP [8] = '{
		32'd4283353945, 32'd4271771997, 32'd4248727704, 32'd4202935003,
		32'd4112874813, 32'd3938502276, 32'd3611622603, 32'd3037000500
	};

	typedef enum logic [1:0] {
		OP_ACCUM = 2'd0,
		OP_LOAD  = 2'd1,
		OP_DIAG  = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SQUARE,
		ST_ACCUM,
		ST_EXPO,
		ST_ROM,
		ST_PROD,
		ST_ROUND,
		ST_DIAG,
		ST_DIAG_RES,
		ST_DONE
	} state_t;

	// 2^(-f/256) in Q.16, built from the per-bit step constants
	function automatic logic [GK_ROM_W-1:0] exp_frac(input logic [7:0] f);
		logic [63:0] r;
		logic [63:0] r_rnd;
		r = 64'h1_0000_0000;
		for (int k = 0; k < 8; k++) begin
			if (f[k]) begin
				r = (r * {32'd0, GK_EXP_STEP[k]} + 64'h8000_0000) >> 32;
			end
		end
		r_rnd = (r + 64'h8000) >> 16;
		return r_rnd[GK_ROM_W-1:0];
	endfunction

endpackage

### sv/agk_in_if.sv
// ----------------------------------------------------------------------------
// agk_in_if
// Input item channel: coordinate pairs, scale loads and diagonal requests.
// ----------------------------------------------------------------------------
interface agk_in_if;
	import agk_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic signed [GK_COORD_W-1:0] coord_a;
	logic signed [GK_COORD_W-1:0] coord_b;
	logic        last_dim;
	logic [3:0]  scale_index;
	logic [GK_SCALE_W-1:0] scale_value;

	modport source (
		output valid, op, coord_a, coord_b, last_dim, scale_index, scale_value,
		input  ready
	);
	modport sink (
		input  valid, op, coord_a, coord_b, last_dim, scale_index, scale_value,
		output ready
	);
endinterface

### sv/agk_out_if.sv
// ----------------------------------------------------------------------------
// agk_out_if
// Result item channel: covariance value and diagonal flag.
// ----------------------------------------------------------------------------
interface agk_out_if;
	import agk_pkg::*;

	logic                valid;
	logic                ready;
	logic [GK_COV_W-1:0] covariance;
	logic                is_diagonal;

	modport source (
		output valid, covariance, is_diagonal,
		input  ready
	);
	modport sink (
		input  valid, covariance, is_diagonal,
		output ready
	);
endinterface

### sv/agk_cfg_if.sv
// ----------------------------------------------------------------------------
// agk_cfg_if
// Configuration write channel for the amplitude register.
// ----------------------------------------------------------------------------
interface agk_cfg_if;
	import agk_pkg::*;

	logic                valid;
	logic                ready;
	logic [GK_AMP_W-1:0] amplitude;

	modport source (
		output valid, amplitude,
		input  ready
	);
	modport sink (
		input  valid, amplitude,
		output ready
	);
endinterface

### sv/agk_ram.sv
// ----------------------------------------------------------------------------
// agk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module agk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

### sv/agk_mul.sv
// ----------------------------------------------------------------------------
// agk_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module agk_mul #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic [WIDTH-1:0]   a,
	input  logic [WIDTH-1:0]   b,
	output logic [2*WIDTH-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
	end

endmodule

### sv/agk_exp_rom.sv
// ----------------------------------------------------------------------------
// agk_exp_rom
// 256-entry table of 2^(-f/256) in Q.16 with registered read.
// ----------------------------------------------------------------------------
module agk_exp_rom
	import agk_pkg::*;
(
	input  logic                clk,
	input  logic [7:0]          idx,
	output logic [GK_ROM_W-1:0] data_q
);

	logic [GK_ROM_W-1:0] rom_w [GK_ROM_DEPTH];

	for (genvar g = 0; g < GK_ROM_DEPTH; g++) begin : g_rom
		assign rom_w[g] = exp_frac(8'(g));
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[idx];
	end

endmodule

### sv/ard_gaussian_kernel_element.sv
// ----------------------------------------------------------------------------
// ard_gaussian_kernel_element
// ARD squared-exponential covariance: amp^2 * exp(-0.5 * sum((d_i*inv_i)^2)),
// one coordinate pair per item, on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | moves
//  req     | in  | op, coord_a, coord_b, last_dim, scale_index/value | one item
//  rsp     | out | covariance, is_diagonal                          | one result
//  cfg     | in  | amplitude                                        | one write
//
//  Op 0 without last_dim: scale and square on the multiplier, then add.
//  Op 0 with last_dim: the same to the result register, plus exponent, amp^2,
//  fraction product and rounding shift. Op 2: amp^2. Op 1 and op 3 keep it idle.
//  The multiplier is the one resource each step waits on; req.ready is low
//  while a step is in flight or a finished result waits for rsp.ready.
//  Reset: amplitude 1.0, counter and accumulator cleared; scale table unset.
// ----------------------------------------------------------------------------
module ard_gaussian_kernel_element
	import agk_pkg::*;
#(
	parameter int DIMS = GK_DIMS
) (
	input  logic       clk,
	input  logic       arst_n,
	agk_in_if.sink     req,
	agk_out_if.source  rsp,
	agk_cfg_if.sink    cfg
);

	localparam int DimW = (DIMS > 1) ? $clog2(DIMS) : 1;

	state_t state_q, state_d;

	logic [GK_AMP_W-1:0]   amp_q;
	logic [DimW-1:0]       dim_q;
	logic [31:0]           acc_q;
	logic                  out_valid_q;
	logic [GK_COV_W-1:0]   out_cov_q;
	logic                  out_diag_q;

	logic [16:0]           mag_q;
	logic                  last_q;
	logic [5:0]            sm1_q;
	logic                  zero_q;
	logic [GK_COV_W-1:0]   res_q;
	logic                  diag_q;

	logic                  accept;
	logic [GK_MUL_W-1:0]   mul_a, mul_b;
	logic [2*GK_MUL_W-1:0] prod;
	logic [GK_SCALE_W-1:0] scale_rd;
	logic [GK_ROM_W-1:0]   rom_rd;
	logic [DimW+3:0]       dim_ext;
	logic signed [16:0]    diff;
	logic [16:0]           mag;
	logic [40:0]           sum;
	logic [31:0]           acc_next;
	logic [15:0]           n_int;
	logic [49:0]           rnd;
	logic [48:0]           rnd_v;
	logic [GK_COV_W-1:0]   cov_val;
	logic                  out_free;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.covariance  = out_cov_q;
	assign rsp.is_diagonal = out_diag_q;

	assign dim_ext = (DimW + 4)'(dim_q);

	agk_ram #(
		.WIDTH (GK_SCALE_W),
		.DEPTH (GK_TBL_DEPTH)
	) u_scale_tbl (
		.clk     (clk),
		.we      (accept && (req.op == OP_LOAD)),
		.waddr   (req.scale_index),
		.wdata   (req.scale_value),
		.raddr   (dim_ext[GK_TBL_AW-1:0]),
		.rdata_q (scale_rd)
	);

	agk_mul #(
		.WIDTH (GK_MUL_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	agk_exp_rom u_rom (
		.clk    (clk),
		.idx    (prod[47:40]),
		.data_q (rom_rd)
	);

	// datapath arithmetic
	assign diff = {req.coord_a[15], req.coord_a} - {req.coord_b[15], req.coord_b};
	assign mag  = diff[16] ? 17'(-diff) : 17'(diff);

	// round half up of sq >> 24 folded into the accumulate
	assign sum      = 41'(acc_q) + 41'(prod[63:24]) + 41'(prod[23]);
	assign acc_next = (sum[40:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];

	assign n_int = prod[63:48];

	assign rnd     = {1'b0, prod[48:0] >> sm1_q} + 50'd1;
	assign rnd_v   = rnd[49:1];
	assign cov_val = zero_q ? '0 :
		((rnd_v[48:32] != '0) ? 32'hFFFF_FFFF : rnd_v[31:0]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.op)
						OP_ACCUM: state_d = ST_SCALE;
						OP_DIAG:  state_d = ST_DIAG;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCALE:    state_d = ST_SQUARE;
			ST_SQUARE:   state_d = ST_ACCUM;
			ST_ACCUM:    state_d = last_q ? ST_EXPO : ST_IDLE;
			ST_EXPO:     state_d = ST_ROM;
			ST_ROM:      state_d = ST_PROD;
			ST_PROD:     state_d = ST_ROUND;
			ST_ROUND:    state_d = ST_DONE;
			ST_DIAG:     state_d = ST_DIAG_RES;
			ST_DIAG_RES: state_d = ST_DONE;
			ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SCALE: begin
				mul_a = GK_MUL_W'(mag_q);
				mul_b = GK_MUL_W'(scale_rd);
			end
			ST_SQUARE: begin
				mul_a = prod[31:0];
				mul_b = prod[31:0];
			end
			ST_EXPO: begin
				mul_a = acc_q;
				mul_b = GK_LOG2E_HALF;
			end
			ST_ROM, ST_DIAG: begin
				mul_a = GK_MUL_W'(amp_q);
				mul_b = GK_MUL_W'(amp_q);
			end
			ST_PROD: begin
				mul_a = prod[31:0];
				mul_b = GK_MUL_W'(rom_rd);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			amp_q       <= GK_AMP_RESET;
			dim_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				amp_q <= cfg.amplitude;
			end
			if (state_q == ST_ACCUM) begin
				acc_q <= acc_next;
				if (last_q || (dim_q == DimW'(DIMS - 1))) begin
					dim_q <= '0;
				end else begin
					dim_q <= dim_q + DimW'(1);
				end
			end else if (state_q == ST_ROUND) begin
				acc_q <= '0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= mag;
			last_q <= req.last_dim;
		end
		if (state_q == ST_ROM) begin
			zero_q <= (n_int >= GK_N_ZERO);
			sm1_q  <= 6'(n_int[5:0] + 6'd15);
		end
		if (state_q == ST_ROUND) begin
			res_q  <= cov_val;
			diag_q <= 1'b0;
		end else if (state_q == ST_DIAG_RES) begin
			res_q  <= prod[31:0];
			diag_q <= 1'b1;
		end
		if (state_q == ST_DONE && out_free) begin
			out_cov_q  <= res_q;
			out_diag_q <= diag_q;
		end
	end

`ifndef SYNTHESIS
	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		dim_q <= DimW'(DIMS - 1))
		else $error("dimension counter beyond DIMS-1");

	a_acc_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACCUM |=> acc_q >= $past(acc_q))
		else $error("accumulator decreased on accumulate");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && zero_q |=> res_q == '0)
		else $error("large exponent did not give zero");

	a_diag_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.op == OP_DIAG |=> state_q == ST_DIAG)
		else $error("diagonal request not started");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ARD squared-exponential kernel element. An
// initial block queues item streams (directed corner cases, then random
// vector pairs with loads, diagonal and op 3 items mixed in). A falling-edge
// driver sends them in bursts. A rising-edge monitor predicts each accepted
// item and checks every result against the oldest prediction. The amplitude
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import agk_pkg::*;

	localparam logic [1:0] OP_RSVD          = 2'd3;
	localparam int         PHASES           = 6;
	localparam int         RANDOM_PER_PHASE = 155;
	localparam int         IDLE_LIMIT       = 3000;
	localparam int         SETTLE_CYCLES    = 16;
	localparam int         HOLD_CYCLES      = 400;
	localparam int         HOLD_AFTER       = 25;
	localparam bit [7:0]   READY_PATTERN    = 8'b1011_0010;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] coord_a;
		logic [15:0] coord_b;
		logic        last_dim;
		logic [3:0]  scale_index;
		logic [15:0] scale_value;
	} req_item_t;

	typedef struct packed {
		logic [31:0] cov;
		logic        diag;
	} cov_result_t;

	logic clk;
	logic arst_n;

	agk_in_if  req_if ();
	agk_out_if rsp_if ();
	agk_cfg_if cfg_if ();

	ard_gaussian_kernel_element uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	req_item_t   pending_items [$];
	cov_result_t expected_cov [$];

	// kernel state as the block should hold it
	bit [15:0] amp_m;
	bit [15:0] inv_scale_m [GK_TBL_DEPTH];
	int        dim_m;
	bit [31:0] acc_m;

	// stimulus-side view of the dimension counter and loaded entries
	int        gen_dim;
	bit [15:0] gen_loaded;
	int        random_cnt;

	int        fail_cnt;
	int        idle_cycles;
	int        rsp_seen;
	bit        in_fire;
	int        burst_left;
	int        gap_left;
	bit [31:0] rcv_cyc;
	int        hold_left;
	bit        hold_done;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit [63:0] exp_step_q32(input int k);
		case (k)
			0: return 64'd4283353945;
			1: return 64'd4271771997;
			2: return 64'd4248727704;
			3: return 64'd4202935003;
			4: return 64'd4112874813;
			5: return 64'd3938502276;
			6: return 64'd3611622603;
			default: return 64'd3037000500;
		endcase
	endfunction

	// 2^(-f/256) in Q.16
	function automatic bit [63:0] exp2_neg_frac(input bit [7:0] f);
		bit [63:0] r;
		r = 64'h1_0000_0000;
		for (int k = 0; k < 8; k++) begin
			if (f[k]) begin
				r = (r * exp_step_q32(k) + 64'h8000_0000) >> 32;
			end
		end
		return (r + 64'h8000) >> 16;
	endfunction

	function automatic bit [31:0] scale_by_exp(input bit [31:0] acc, input bit [15:0] amp);
		bit [63:0] y;
		bit [63:0] s;
		bit [63:0] p;
		bit [63:0] v;
		y = {32'd0, acc} * 64'd3098164010;
		s = 64'd16 + (y >> 48);
		p = ({48'd0, amp} * {48'd0, amp}) * exp2_neg_frac(y[47:40]);
		if (s >= 64'd60) begin
			return 32'd0;
		end
		v = (p + (64'd1 << (s - 64'd1))) >> s;
		if (v > 64'hFFFF_FFFF) begin
			return 32'hFFFF_FFFF;
		end
		return v[31:0];
	endfunction

	task automatic predict_kernel(input req_item_t it);
		int          d;
		bit [63:0]   mag;
		bit [63:0]   t;
		bit [63:0]   sq;
		bit [63:0]   sum;
		cov_result_t r;
		case (it.op)
			OP_LOAD: begin
				inv_scale_m[it.scale_index] = it.scale_value;
			end
			OP_DIAG: begin
				r.cov  = {16'd0, amp_m} * {16'd0, amp_m};
				r.diag = 1'b1;
				expected_cov.push_back(r);
			end
			OP_ACCUM: begin
				d   = int'($signed(it.coord_a)) - int'($signed(it.coord_b));
				mag = 64'((d < 0) ? -d : d);
				t   = mag * inv_scale_m[GK_TBL_AW'(dim_m % GK_TBL_DEPTH)];
				sq  = t * t;
				sum = {32'd0, acc_m} + (((sq >> 23) + 64'd1) >> 1);
				acc_m = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
				if (it.last_dim) begin
					r.cov  = scale_by_exp(acc_m, amp_m);
					r.diag = 1'b0;
					expected_cov.push_back(r);
					acc_m = 32'd0;
					dim_m = 0;
				end else begin
					dim_m = (dim_m + 1 >= GK_DIMS) ? 0 : dim_m + 1;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic bit [15:0] rand_scale();
		if ($urandom_range(0, 2) != 0) begin
			return 16'($urandom_range(0, 8191));
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic push_item(input logic [1:0] op, input logic [15:0] a, input logic [15:0] b,
			input logic last, input logic [3:0] idx, input logic [15:0] val);
		req_item_t it;
		it.op          = op;
		it.coord_a     = a;
		it.coord_b     = b;
		it.last_dim    = last;
		it.scale_index = idx;
		it.scale_value = val;
		pending_items.push_back(it);
		if (op != OP_RSVD) begin
			random_cnt++;
		end
	endtask

	task automatic push_load(input logic [3:0] idx, input logic [15:0] val);
		gen_loaded[idx] = 1'b1;
		push_item(OP_LOAD, 16'($urandom), 16'($urandom), 1'($urandom), idx, val);
	endtask

	// never lets an accumulate read a scale entry that was not loaded
	task automatic push_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
		if (!gen_loaded[GK_TBL_AW'(gen_dim % GK_TBL_DEPTH)]) begin
			push_load(GK_TBL_AW'(gen_dim % GK_TBL_DEPTH), rand_scale());
		end
		push_item(OP_ACCUM, a, b, last, 4'($urandom), 16'($urandom));
		if (last) begin
			gen_dim = 0;
		end else begin
			gen_dim = (gen_dim + 1 >= GK_DIMS) ? 0 : gen_dim + 1;
		end
	endtask

	task automatic push_vector();
		int          len;
		int          sel;
		bit          near;
		logic [15:0] a;
		logic [15:0] b;
		sel = $urandom_range(0, 19);
		if (sel < 15) begin
			len = $urandom_range(1, 4);
		end else if (sel < 19) begin
			len = $urandom_range(5, 16);
		end else begin
			len = $urandom_range(17, 24);
		end
		near = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < len; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				push_load(4'($urandom_range(0, 15)), rand_scale());
			end else if (sel < 17) begin
				push_item(OP_DIAG, 16'($urandom), 16'($urandom), 1'($urandom),
					4'($urandom), 16'($urandom));
			end else if (sel < 20) begin
				push_item(OP_RSVD, 16'($urandom), 16'($urandom), 1'($urandom),
					4'($urandom), 16'($urandom));
			end
			if (near) begin
				a = 16'($urandom_range(0, 8191) - 4096);
				b = 16'(a + $urandom_range(0, 2048) - 1024);
			end else begin
				a = 16'($urandom);
				b = 16'($urandom);
			end
			push_pair(a, b, i == len - 1);
		end
	endtask

	task automatic write_amplitude(input logic [15:0] v);
		@(negedge clk);
		cfg_if.valid     <= 1'b1;
		cfg_if.amplitude <= v;
		@(posedge clk);
		while (!cfg_if.ready) begin
			@(posedge clk);
		end
		amp_m = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_cov.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin : drive_req
		if (arst_n !== 1'b1) begin
			req_if.valid <= 1'b0;
		end else if (!(req_if.valid && !in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_if.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				req_if.valid       <= 1'b1;
				req_if.op          <= pending_items[0].op;
				req_if.coord_a     <= pending_items[0].coord_a;
				req_if.coord_b     <= pending_items[0].coord_b;
				req_if.last_dim    <= pending_items[0].last_dim;
				req_if.scale_index <= pending_items[0].scale_index;
				req_if.scale_value <= pending_items[0].scale_value;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_rsp_ready
		rcv_cyc++;
		if (!hold_done && rsp_seen >= HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			case (rcv_cyc[7:6])
				2'd0: rsp_if.ready <= 1'b1;
				2'd1: rsp_if.ready <= 1'($urandom_range(0, 1));
				2'd2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_if.ready <= READY_PATTERN[rcv_cyc[2:0]];
			endcase
		end
	end

	always @(posedge clk) begin : monitor
		req_item_t   it;
		cov_result_t want;
		bit          out_fire;
		in_fire  = (arst_n === 1'b1) && req_if.valid && req_if.ready;
		out_fire = (arst_n === 1'b1) && rsp_if.valid && rsp_if.ready;
		if (out_fire) begin
			rsp_seen++;
			if (expected_cov.size() == 0) begin
				$error("unexpected result: covariance %h is_diagonal %b",
					rsp_if.covariance, rsp_if.is_diagonal);
				fail_cnt++;
			end else begin
				want = expected_cov.pop_front();
				if (rsp_if.covariance !== want.cov) begin
					$error("covariance: expected %h, got %h", want.cov, rsp_if.covariance);
					fail_cnt++;
				end
				if (rsp_if.is_diagonal !== want.diag) begin
					$error("is_diagonal: expected %b, got %b", want.diag, rsp_if.is_diagonal);
					fail_cnt++;
				end
			end
		end
		if (in_fire) begin
			it = pending_items.pop_front();
			predict_kernel(it);
		end
		if (in_fire || out_fire || (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : main
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.op          = OP_ACCUM;
		req_if.coord_a     = '0;
		req_if.coord_b     = '0;
		req_if.last_dim    = 1'b0;
		req_if.scale_index = '0;
		req_if.scale_value = '0;
		rsp_if.ready       = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.amplitude   = GK_AMP_RESET;
		amp_m              = GK_AMP_RESET;
		acc_m              = '0;
		dim_m              = 0;
		for (int i = 0; i < GK_TBL_DEPTH; i++) begin
			inv_scale_m[i] = '0;
		end
		gen_dim    = 0;
		gen_loaded = '0;
		fail_cnt   = 0;
		idle_cycles = 0;
		rsp_seen   = 0;
		in_fire    = 1'b0;
		burst_left = 0;
		gap_left   = 0;
		rcv_cyc    = '0;
		hold_left  = 0;
		hold_done  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero distance, saturating sums, zero scale, mid-vector load/diag, op 3
		push_item(OP_DIAG, 16'h0000, 16'h0000, 1'b0, 4'h0, 16'h0000);
		push_load(4'h0, 16'h1000);
		push_pair(16'h0000, 16'h0000, 1'b1);
		push_pair(16'h7FFF, 16'h8000, 1'b1);
		push_load(4'h0, 16'hFFFF);
		push_pair(16'h8000, 16'h7FFF, 1'b1);
		push_load(4'h0, 16'h0000);
		push_pair(16'h7FFF, 16'h8000, 1'b1);
		push_load(4'h0, 16'h0800);
		push_load(4'h1, 16'h1000);
		push_pair(16'h0100, 16'h0000, 1'b0);
		push_load(4'h2, 16'h0400);
		push_item(OP_DIAG, 16'hFFFF, 16'hFFFF, 1'b1, 4'hF, 16'hFFFF);
		push_item(OP_RSVD, 16'hFFFF, 16'h0000, 1'b1, 4'hF, 16'hFFFF);
		push_pair(16'h0000, 16'hFE00, 1'b0);
		push_pair(16'hFF9C, 16'h0064, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_drained();
				case (ph)
					1: write_amplitude(16'hFFFF);
					2: write_amplitude(16'h0000);
					3: write_amplitude(16'h0001);
					default: write_amplitude(16'($urandom));
				endcase
			end
			random_cnt = 0;
			while (random_cnt < RANDOM_PER_PHASE) begin
				push_vector();
			end
		end

		wait_drained();
		if (fail_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### ard_gaussian_kernel_element.f
sv/agk_pkg.sv
sv/agk_in_if.sv
sv/agk_out_if.sv
sv/agk_cfg_if.sv
sv/agk_ram.sv
sv/agk_mul.sv
sv/agk_exp_rom.sv
sv/ard_gaussian_kernel_element.sv
tb/sv/tb_top.sv
